FILE: rtl/hpq_pkg.sv
package hpq_pkg;

	localparam int CAPACITY = 16;
	localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	// child index math runs one bit wider than the count so 2*pos+2 never wraps
	localparam int WIDE_W   = IDX_W + 2;

	localparam logic MODE_INSERT  = 1'b0;
	localparam logic MODE_EXTRACT = 1'b1;

	typedef enum logic [1:0] {
		STATUS_OK    = 2'd0,
		STATUS_FULL  = 2'd1,
		STATUS_EMPTY = 2'd2
	} hpq_status_t;

	typedef struct packed {
		logic signed [15:0] pri;
		logic signed [31:0] pay;
	} hpq_entry_t;

	localparam int ENTRY_W = $bits(hpq_entry_t);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_START,
		ST_EXT,
		ST_UP,
		ST_DOWN,
		ST_PLACE,
		ST_FIN
	} hpq_state_t;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_CAPTURE,
		OP_START,
		OP_EXT,
		OP_UP,
		OP_DOWN,
		OP_PLACE,
		OP_LOAD
	} hpq_op_t;

	typedef struct packed {
		logic is_ins;
		logic full;
		logic empty;
		logic up_swap;
		logic up_top;
		logic down_swap;
	} hpq_sts_t;

endpackage

FILE: rtl/hpq_if.sv
interface hpq_req_if;
	logic               valid;
	logic               ready;
	logic               mode;
	logic signed [15:0] priority_req;
	logic signed [31:0] payload;

	modport source (output valid, output mode, output priority_req, output payload,
		input ready);
	modport sink (input valid, input mode, input priority_req, input payload,
		output ready);
endinterface

interface hpq_rsp_if;
	logic               valid;
	logic               ready;
	logic [1:0]         status;
	logic signed [15:0] out_priority;
	logic signed [31:0] out_payload;

	modport source (output valid, output status, output out_priority, output out_payload,
		input ready);
	modport sink (input valid, input status, input out_priority, input out_payload,
		output ready);
endinterface

FILE: rtl/hpq_ram.sv
module hpq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	output logic [WIDTH-1:0]         rdata_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_a <= mem_q[raddr_a];
		rdata_b <= mem_q[raddr_b];
	end

endmodule

FILE: rtl/hpq_dp.sv
module hpq_dp (
	input  logic               clk,
	input  logic               arst_n,
	input  hpq_pkg::hpq_op_t   op,
	input  logic               in_mode,
	input  logic signed [15:0] in_priority,
	input  logic signed [31:0] in_payload,
	output hpq_pkg::hpq_sts_t  sts,
	output logic [1:0]         out_status,
	output logic signed [15:0] out_priority,
	output logic signed [31:0] out_payload
);
	import hpq_pkg::*;

	logic [CNT_W-1:0]   cnt_q;
	logic [CNT_W-1:0]   cnt_dec;
	logic [IDX_W-1:0]   pos_q;
	logic               mode_q;
	hpq_entry_t         ent_q;
	hpq_entry_t         res_q;
	hpq_status_t        status_q;
	hpq_status_t        out_status_q;
	hpq_entry_t         out_q;

	logic               we;
	logic [IDX_W-1:0]   waddr;
	hpq_entry_t         wdata;
	logic [IDX_W-1:0]   raddr_a;
	logic [IDX_W-1:0]   raddr_b;
	logic [ENTRY_W-1:0] rdata_a;
	logic [ENTRY_W-1:0] rdata_b;
	hpq_entry_t         rd_a_e;
	hpq_entry_t         rd_b_e;

	logic [IDX_W-1:0]   par;
	logic [IDX_W-1:0]   gpar;
	logic [IDX_W-1:0]   ins_par;
	logic [WIDE_W-1:0]  lc_w;
	logic [WIDE_W-1:0]  rc_w;
	logic [WIDE_W-1:0]  cnt_w;
	logic               lc_ok;
	logic               rc_ok;
	logic               take_l;
	logic               take_r;
	logic signed [15:0] best_pri;
	hpq_entry_t         child_e;
	logic [IDX_W-1:0]   child_idx;
	logic [WIDE_W-1:0]  nlc_w;
	logic [WIDE_W-1:0]  nrc_w;
	logic               is_ins;
	logic               full;
	logic               empty;
	logic               up_swap;
	logic               down_swap;

	hpq_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (CAPACITY)
	) u_heap_ram (
		.clk     (clk),
		.we      (we),
		.waddr   (waddr),
		.wdata   (wdata),
		.raddr_a (raddr_a),
		.rdata_a (rdata_a),
		.raddr_b (raddr_b),
		.rdata_b (rdata_b)
	);

	assign rd_a_e = hpq_entry_t'(rdata_a);
	assign rd_b_e = hpq_entry_t'(rdata_b);

	assign is_ins  = (mode_q == MODE_INSERT);
	assign full    = (cnt_q == CNT_W'(CAPACITY));
	assign empty   = (cnt_q == '0);
	assign cnt_dec = cnt_q - CNT_W'(1);

	// parent of the hole, its parent, and parent of the new tail slot
	assign par     = (pos_q - IDX_W'(1)) >> 1;
	assign gpar    = (par - IDX_W'(1)) >> 1;
	assign ins_par = (cnt_q[IDX_W-1:0] - IDX_W'(1)) >> 1;

	assign up_swap = (rd_a_e.pri < ent_q.pri);

	// children of the hole; slots at or above the count do not exist
	assign lc_w  = {1'b0, pos_q, 1'b1};
	assign rc_w  = lc_w + WIDE_W'(1);
	assign cnt_w = WIDE_W'(cnt_q);
	assign lc_ok = (lc_w < cnt_w);
	assign rc_ok = (rc_w < cnt_w);

	// left child wins ties: right must be strictly greater than the best so far
	assign take_l    = lc_ok && (rd_a_e.pri > ent_q.pri);
	assign best_pri  = take_l ? rd_a_e.pri : ent_q.pri;
	assign take_r    = rc_ok && (rd_b_e.pri > best_pri);
	assign down_swap = take_l || take_r;
	assign child_e   = take_r ? rd_b_e : rd_a_e;
	assign child_idx = take_r ? rc_w[IDX_W-1:0] : lc_w[IDX_W-1:0];
	assign nlc_w     = {1'b0, child_idx, 1'b1};
	assign nrc_w     = nlc_w + WIDE_W'(1);

	assign sts = '{
		is_ins:    is_ins,
		full:      full,
		empty:     empty,
		up_swap:   up_swap,
		up_top:    (par == '0),
		down_swap: down_swap
	};

	always_comb begin
		we      = 1'b0;
		waddr   = pos_q;
		wdata   = ent_q;
		raddr_a = '0;
		raddr_b = '0;
		unique case (op)
			OP_START: begin
				if (is_ins) begin
					raddr_a = ins_par;
				end else begin
					raddr_b = cnt_dec[IDX_W-1:0];
				end
			end
			OP_EXT: begin
				raddr_a = IDX_W'(1);
				raddr_b = IDX_W'(2);
			end
			OP_UP: begin
				raddr_a = gpar;
				if (up_swap) begin
					we    = 1'b1;
					wdata = rd_a_e;
				end
			end
			OP_DOWN: begin
				raddr_a = nlc_w[IDX_W-1:0];
				raddr_b = nrc_w[IDX_W-1:0];
				if (down_swap) begin
					we    = 1'b1;
					wdata = child_e;
				end
			end
			OP_PLACE: begin
				we = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (op == OP_START) begin
			if (is_ins && !full) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (!is_ins && !empty) begin
				cnt_q <= cnt_dec;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (op)
			OP_CAPTURE: begin
				mode_q    <= in_mode;
				ent_q.pri <= in_priority;
				ent_q.pay <= in_payload;
			end
			OP_START: begin
				res_q <= '0;
				pos_q <= cnt_q[IDX_W-1:0];
				if (is_ins && full) begin
					status_q <= STATUS_FULL;
				end else if (!is_ins && empty) begin
					status_q <= STATUS_EMPTY;
				end else begin
					status_q <= STATUS_OK;
				end
			end
			OP_EXT: begin
				res_q <= rd_a_e;
				ent_q <= rd_b_e;
				pos_q <= '0;
			end
			OP_UP: begin
				if (up_swap) begin
					pos_q <= par;
				end
			end
			OP_DOWN: begin
				if (down_swap) begin
					pos_q <= child_idx;
				end
			end
			OP_LOAD: begin
				out_status_q <= status_q;
				out_q        <= res_q;
			end
			default: begin
			end
		endcase
	end

	assign out_status   = out_status_q;
	assign out_priority = out_q.pri;
	assign out_payload  = out_q.pay;

endmodule

FILE: rtl/hpq_ctrl.sv
module hpq_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  hpq_pkg::hpq_sts_t sts,
	output hpq_pkg::hpq_op_t  op
);
	import hpq_pkg::*;

	hpq_state_t state_q;
	hpq_state_t state_d;
	logic       out_valid_q;
	logic       out_valid_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		op          = OP_NONE;
		in_ready    = 1'b0;
		out_valid_d = out_valid_q && !out_ready;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					op      = OP_CAPTURE;
					state_d = ST_START;
				end
			end
			ST_START: begin
				op = OP_START;
				if (sts.is_ins) begin
					if (sts.full) begin
						state_d = ST_FIN;
					end else if (sts.empty) begin
						state_d = ST_PLACE;
					end else begin
						state_d = ST_UP;
					end
				end else if (sts.empty) begin
					state_d = ST_FIN;
				end else begin
					state_d = ST_EXT;
				end
			end
			ST_EXT: begin
				op = OP_EXT;
				// count already dropped: nothing left to sift
				state_d = sts.empty ? ST_FIN : ST_DOWN;
			end
			ST_UP: begin
				op = OP_UP;
				if (sts.up_swap && !sts.up_top) begin
					state_d = ST_UP;
				end else begin
					state_d = ST_PLACE;
				end
			end
			ST_DOWN: begin
				op      = OP_DOWN;
				state_d = sts.down_swap ? ST_DOWN : ST_PLACE;
			end
			ST_PLACE: begin
				op      = OP_PLACE;
				state_d = ST_FIN;
			end
			ST_FIN: begin
				if (!out_valid_q || out_ready) begin
					op          = OP_LOAD;
					out_valid_d = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

FILE: rtl/binary_max_heap_priority_queue_unit.sv
// Channel  Dir  Payload                                   Transaction
// req      in   mode, priority_req[15:0], payload[31:0]   valid && ready
// rsp      out  status[1:0], out_priority[15:0],          valid && ready
//               out_payload[31:0]
//
// One item at a time. After acceptance an insert runs start, u parent compares (0 to 4)
// and place; an extract runs start, root and tail fetch, a sift of d levels (0 to 3), place.
// Each then loads its result. A dropped insert or an empty extract goes from start to the
// load, an extract of the last entry skips sift and place. Only idle takes a request.
// Reset clears the count, sequencer and result valid; heap RAM is not cleared.
// A stalled rsp holds its result; the next request runs and waits in its final state.
module binary_max_heap_priority_queue_unit (
	input logic     clk,
	input logic     arst_n,
	hpq_req_if.sink req,
	hpq_rsp_if.source rsp
);
	import hpq_pkg::*;

	hpq_op_t  op;
	hpq_sts_t sts;

	// sequencer: one state per phase of a sift, one op per cycle to the datapath
	hpq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.sts       (sts),
		.op        (op)
	);

	// heap RAM, hole position, moving entry, count and result registers
	hpq_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.op           (op),
		.in_mode      (req.mode),
		.in_priority  (req.priority_req),
		.in_payload   (req.payload),
		.sts          (sts),
		.out_status   (rsp.status),
		.out_priority (rsp.out_priority),
		.out_payload  (rsp.out_payload)
	);

endmodule
